>>> design/sbns_pkg.sv
// Package for the sequence bytecode note scanner.
// Holds the transfer structs, opcode codes and the command size table.
// No dependencies.
package sbns_pkg;

	// Fixed field widths
	localparam int FIELD_ADDR_W = 24;
	localparam int WIDE_ADDR_W  = 32;
	localparam int LEN_W        = 3;

	// Record kinds
	localparam logic REC_NOTE       = 1'b0;
	localparam logic REC_REPEAT_END = 1'b1;

	// Opcodes with special handling
	localparam logic [7:0] OP_NOTE_LIMIT   = 8'h80;
	localparam logic [7:0] OP_PATTERN_END  = 8'h80;
	localparam logic [7:0] OP_REPEAT_BEGIN = 8'h8d;
	localparam logic [7:0] OP_REPEAT_END   = 8'h8e;
	localparam logic [7:0] OP_SET_IMPLIED  = 8'h9e;

	// One input byte with its side information
	typedef struct packed {
		logic [7:0]              data_byte;
		logic [FIELD_ADDR_W-1:0] byte_addr;
		logic                    pattern_start;
		logic [7:0]              pattern_index;
		logic                    last_byte;
	} scan_item_t;

	// One note or repeat-end record
	typedef struct packed {
		logic                    record_kind;
		logic [FIELD_ADDR_W-1:0] command_addr;
		logic [6:0]              note_key;
		logic [7:0]              note_duration;
		logic [7:0]              note_velocity;
		logic                    duration_implied;
		logic                    velocity_implied;
		logic [FIELD_ADDR_W-1:0] repeat_target_addr;
		logic [7:0]              repeat_target_pattern;
	} scan_rec_t;

	// Length in bytes of commands 0x80..0x9e, indexed by the low five bits.
	// Zero marks an undefined command; index 31 (0x9f) is undefined too.
	function automatic logic [LEN_W-1:0] cmd_len(input logic [4:0] idx);
		logic [LEN_W-1:0] len;
		unique case (idx)
			5'd0:  len = 3'd1;
			5'd1:  len = 3'd3;
			5'd2:  len = 3'd3;
			5'd3:  len = 3'd4;
			5'd4:  len = 3'd3;
			5'd5:  len = 3'd3;
			5'd6:  len = 3'd3;
			5'd7:  len = 3'd3;
			5'd8:  len = 3'd3;
			5'd9:  len = 3'd3;
			5'd10: len = 3'd3;
			5'd11: len = 3'd0;
			5'd12: len = 3'd0;
			5'd13: len = 3'd1;
			5'd14: len = 3'd2;
			5'd15: len = 3'd2;
			5'd16: len = 3'd3;
			5'd17: len = 3'd3;
			5'd18: len = 3'd3;
			5'd19: len = 3'd3;
			5'd20: len = 3'd5;
			5'd21: len = 3'd3;
			5'd22: len = 3'd3;
			5'd23: len = 3'd6;
			5'd24: len = 3'd0;
			5'd25: len = 3'd3;
			5'd26: len = 3'd3;
			5'd27: len = 3'd7;
			5'd28: len = 3'd0;
			5'd29: len = 3'd0;
			5'd30: len = 3'd3;
			default: len = 3'd0;
		endcase
		return len;
	endfunction

endpackage

>>> design/sequence_bytecode_note_scanner_unit.sv
// Sequence bytecode note scanner, top level.
// Depends on sbns_pkg (transfer structs, opcode codes, command size table).
//
// Usage:
//   Input channel item_valid / item_stall / item carries one bytecode byte
//   per transfer with its address, pattern start flag, pattern index and a
//   last-byte flag. Output channel rec_valid / rec_stall / rec carries note
//   records and repeat-end records; a byte yields zero or one record.
//   A transfer takes place on a clock edge with valid high and stall low.
// Path: a byte is held in the input register, then parsed against the scan
//   state in one pass of table lookup and compares; its record is written
//   to the output register when the parse step advances, and leaves from
//   there while rec_stall is low.
// Throughput: one byte per cycle while the output register is not stalled
//   full; the parse step updates the scan state for every byte.
// Stall: a full output register that is stalled holds the input register,
//   which raises item_stall; nothing is dropped.
// Reset (arst_n low, asynchronous): both registers empty, the scanner halted
//   until a byte flagged as a pattern start, implied values and the repeat
//   target cleared.
module sequence_bytecode_note_scanner_unit
	import sbns_pkg::*;
#(
	parameter int ADDR_BITS = FIELD_ADDR_W
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	output logic       item_stall,
	input  scan_item_t item,
	output logic       rec_valid,
	input  logic       rec_stall,
	output scan_rec_t  rec
);

	// Input register
	logic       item_valid_s1;
	scan_item_t item_s1;

	// Scan state
	logic                 collecting_q;
	logic                 halted_q;
	logic [7:0]           cur_op_q;
	logic [ADDR_BITS-1:0] cur_addr_q;
	logic [LEN_W-1:0]     bytes_rem_q;
	logic [LEN_W-1:0]     opnd_cnt_q;
	logic [7:0]           opnd0_q;
	logic [7:0]           opnd1_q;
	logic [7:0]           opnd2_q;
	logic [7:0]           impl_dur_q;
	logic [7:0]           impl_vel_q;
	logic                 rep_valid_q;
	logic [ADDR_BITS-1:0] rep_dest_q;
	logic [7:0]           rep_pattern_q;

	// Output register
	logic      rec_valid_q;
	scan_rec_t rec_q;

	// Next-state values
	logic                 collecting_n;
	logic                 halted_n;
	logic [7:0]           cur_op_n;
	logic [ADDR_BITS-1:0] cur_addr_n;
	logic [LEN_W-1:0]     bytes_rem_n;
	logic [LEN_W-1:0]     opnd_cnt_n;
	logic [7:0]           opnd0_n;
	logic [7:0]           opnd1_n;
	logic [7:0]           opnd2_n;
	logic [7:0]           impl_dur_n;
	logic [7:0]           impl_vel_n;
	logic                 rep_valid_n;
	logic [ADDR_BITS-1:0] rep_dest_n;
	logic [7:0]           rep_pattern_n;
	logic                 has_rec;
	scan_rec_t            rec_n;

	logic                   advance;
	logic [WIDE_ADDR_W-1:0] byte_addr_wide;
	logic [ADDR_BITS-1:0]   byte_addr_in;

	// Parse step moves when the output register is free or being emptied
	assign advance    = item_valid_s1 && (!rec_valid_q || !rec_stall);
	assign item_stall = item_valid_s1 && !advance;
	assign rec_valid  = rec_valid_q;
	assign rec        = rec_q;

	assign byte_addr_wide = WIDE_ADDR_W'(item_s1.byte_addr);
	assign byte_addr_in   = byte_addr_wide[ADDR_BITS-1:0];

	// Parse one byte against the scan state
	always_comb begin
		logic [LEN_W-1:0]       size;
		logic                   fin;
		logic                   di;
		logic                   vi;
		logic [WIDE_ADDR_W-1:0] addr_w;
		logic [WIDE_ADDR_W-1:0] dest_w;

		collecting_n  = collecting_q;
		halted_n      = halted_q;
		cur_op_n      = cur_op_q;
		cur_addr_n    = cur_addr_q;
		bytes_rem_n   = bytes_rem_q;
		opnd_cnt_n    = opnd_cnt_q;
		opnd0_n       = opnd0_q;
		opnd1_n       = opnd1_q;
		opnd2_n       = opnd2_q;
		impl_dur_n    = impl_dur_q;
		impl_vel_n    = impl_vel_q;
		rep_valid_n   = rep_valid_q;
		rep_dest_n    = rep_dest_q;
		rep_pattern_n = rep_pattern_q;
		has_rec       = 1'b0;
		rec_n         = '0;
		size          = '0;
		fin           = 1'b0;
		di            = 1'b0;
		vi            = 1'b0;
		addr_w        = '0;
		dest_w        = '0;

		// Pattern start drops any partial command and ends the halt
		if (item_s1.pattern_start) begin
			halted_n     = 1'b0;
			collecting_n = 1'b0;
			bytes_rem_n  = '0;
			opnd_cnt_n   = '0;
			impl_dur_n   = '0;
			impl_vel_n   = '0;
		end

		if (!halted_n) begin
			if (!collecting_n) begin
				// Opcode byte
				cur_op_n   = item_s1.data_byte;
				cur_addr_n = byte_addr_in;
				opnd_cnt_n = '0;
				if (item_s1.data_byte < OP_NOTE_LIMIT) begin
					size = LEN_W'(2) + LEN_W'(impl_dur_n == '0) + LEN_W'(impl_vel_n == '0);
				end else begin
					size = cmd_len(item_s1.data_byte[4:0]);
				end
				if (item_s1.data_byte >= OP_NOTE_LIMIT &&
					(item_s1.data_byte > OP_SET_IMPLIED ||
					 item_s1.data_byte == OP_PATTERN_END || size == '0)) begin
					halted_n = 1'b1;
				end else begin
					bytes_rem_n = size - LEN_W'(1);
					if (bytes_rem_n == '0) begin
						fin = 1'b1;
					end else begin
						collecting_n = 1'b1;
					end
				end
			end else begin
				// Operand byte; only the first three are kept
				unique case (opnd_cnt_n)
					3'd0:    opnd0_n = item_s1.data_byte;
					3'd1:    opnd1_n = item_s1.data_byte;
					3'd2:    opnd2_n = item_s1.data_byte;
					default: ;
				endcase
				opnd_cnt_n  = opnd_cnt_n + LEN_W'(1);
				bytes_rem_n = bytes_rem_n - LEN_W'(1);
				if (bytes_rem_n == '0) begin
					collecting_n = 1'b0;
					fin          = 1'b1;
				end
			end
		end

		// Command complete
		addr_w = WIDE_ADDR_W'(cur_addr_n);
		if (fin) begin
			if (cur_op_n < OP_NOTE_LIMIT) begin
				di                     = impl_dur_n != '0;
				vi                     = impl_vel_n != '0;
				has_rec                = 1'b1;
				rec_n.record_kind      = REC_NOTE;
				rec_n.command_addr     = addr_w[FIELD_ADDR_W-1:0];
				rec_n.note_key         = cur_op_n[6:0];
				rec_n.note_duration    = di ? impl_dur_n : opnd1_n;
				rec_n.note_velocity    = vi ? impl_vel_n : (di ? opnd1_n : opnd2_n);
				rec_n.duration_implied = di;
				rec_n.velocity_implied = vi;
			end else if (cur_op_n == OP_REPEAT_BEGIN) begin
				rep_valid_n   = 1'b1;
				rep_dest_n    = cur_addr_n + ADDR_BITS'(1);
				rep_pattern_n = item_s1.pattern_index;
			end else if (cur_op_n == OP_REPEAT_END) begin
				if (rep_valid_q) begin
					dest_w                      = WIDE_ADDR_W'(rep_dest_q);
					has_rec                     = 1'b1;
					rec_n.record_kind           = REC_REPEAT_END;
					rec_n.command_addr          = addr_w[FIELD_ADDR_W-1:0];
					rec_n.repeat_target_addr    = dest_w[FIELD_ADDR_W-1:0];
					rec_n.repeat_target_pattern = rep_pattern_q;
				end
			end else if (cur_op_n == OP_SET_IMPLIED) begin
				impl_dur_n = opnd0_n;
				impl_vel_n = opnd1_n;
			end
		end

		// Sequence end halts and drops an unfinished command
		if (item_s1.last_byte) begin
			halted_n     = 1'b1;
			collecting_n = 1'b0;
			bytes_rem_n  = '0;
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			item_valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1 <= item;
		end
	end

	// Scan state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			collecting_q  <= 1'b0;
			halted_q      <= 1'b1;
			cur_op_q      <= '0;
			cur_addr_q    <= '0;
			bytes_rem_q   <= '0;
			opnd_cnt_q    <= '0;
			opnd0_q       <= '0;
			opnd1_q       <= '0;
			opnd2_q       <= '0;
			impl_dur_q    <= '0;
			impl_vel_q    <= '0;
			rep_valid_q   <= 1'b0;
			rep_dest_q    <= '0;
			rep_pattern_q <= '0;
		end else if (advance) begin
			collecting_q  <= collecting_n;
			halted_q      <= halted_n;
			cur_op_q      <= cur_op_n;
			cur_addr_q    <= cur_addr_n;
			bytes_rem_q   <= bytes_rem_n;
			opnd_cnt_q    <= opnd_cnt_n;
			opnd0_q       <= opnd0_n;
			opnd1_q       <= opnd1_n;
			opnd2_q       <= opnd2_n;
			impl_dur_q    <= impl_dur_n;
			impl_vel_q    <= impl_vel_n;
			rep_valid_q   <= rep_valid_n;
			rep_dest_q    <= rep_dest_n;
			rep_pattern_q <= rep_pattern_n;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_valid_q <= 1'b0;
		end else if (advance) begin
			rec_valid_q <= has_rec;
		end else if (rec_valid_q && !rec_stall) begin
			rec_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && has_rec) begin
			rec_q <= rec_n;
		end
	end

	// Checks
	a_rep_end_needs_target: assert property (@(posedge clk) disable iff (!arst_n)
		rec_valid_q && rec_q.record_kind == REC_REPEAT_END |-> rep_valid_q)
		else $error("repeat-end record without a repeat target");

	a_collect_not_halted: assert property (@(posedge clk) disable iff (!arst_n)
		collecting_q |-> !halted_q)
		else $error("collecting operands while halted");

	a_idle_no_remaining: assert property (@(posedge clk) disable iff (!arst_n)
		!collecting_q |-> bytes_rem_q == '0)
		else $error("bytes remaining outside a command");

	a_note_no_target: assert property (@(posedge clk) disable iff (!arst_n)
		rec_valid_q && rec_q.record_kind == REC_NOTE |->
		rec_q.repeat_target_addr == '0 && rec_q.repeat_target_pattern == '0)
		else $error("note record carries repeat fields");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> item_valid_s1 && rec_valid_q)
		else $error("input stalled with room downstream");

endmodule
